### src/pfor_exception_patch_prefix_sum_core_macros.svh
// Assertion shorthands used by the checker file.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef PFOR_EXCEPTION_PATCH_PREFIX_SUM_CORE_MACROS_SVH
`define PFOR_EXCEPTION_PATCH_PREFIX_SUM_CORE_MACROS_SVH

// Same-cycle implication, off during reset.
`define PFOR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off during reset.
`define PFOR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/pfor_pkg.sv
`default_nettype none

package pfor_pkg;

	// input commands
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_LOW   = 2'd1;
	localparam logic [1:0] CMD_EXC   = 2'd2;

	// operations queued from the front end to the back end
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_FILL  = 2'd1;
	localparam logic [1:0] OP_PATCH = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	// entry index width, enough for the largest supported block
	localparam int ADDR_W = 8;

	// operation queue depth, a power of two
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [1:0]  command;
		logic        prefix_mode;
		logic [4:0]  value_width;
		logic [2:0]  exception_count;
		logic [31:0] base;
		logic [31:0] value;
		logic [6:0]  exception_position;
		logic [7:0]  exception_bits;
	} item_t;

	typedef struct packed {
		logic [31:0] first_value;
		logic [31:0] second_value;
		logic [5:0]  pair_index;
		logic        last;
	} pair_t;

	// one queued operation; emit asks for the block to be drained afterwards
	typedef struct packed {
		logic [1:0]        op;
		logic [ADDR_W-1:0] addr;
		logic [31:0]       data;
		logic              emit;
		logic              mode;
		logic [31:0]       base;
	} op_t;

endpackage

`default_nettype wire

### src/pfor_exception_patch_prefix_sum_core.sv
// Finishes one patched frame-of-reference block of BLOCK_LEN 32-bit entries and
// emits it as pairs (entries 2k, 2k+1), plain or as a wrapping running sum from
// base. Input beats are taken one per clock while the four-deep operation queue
// has room; start, low-part and exception beats that arrive out of order are
// taken and dropped. Behind the queue the store unit writes a low part as it
// pops it, handles an exception as a read and then a write back, fills a
// shared value by sweeping one row of both banks per cycle, and drains a block
// at one pair per cycle while the output is not stalled, set by the single read
// port of each bank; a drained row passes the read register, stage 2 and the
// output register in order, and a stalled output holds the drain. An exception
// read also waits while an emitted pair row still sits in the first read stage.
// The entry store has no reset: every entry is written by the fill or the low
// parts before a drain.
`default_nettype none

module pfor_exception_patch_prefix_sum_core #(
	parameter int BLOCK_LEN = 128
) (
	input  wire             logic clk,
	input  wire             logic arst_n,
	input  wire             logic item_valid,
	output logic            item_stall,
	input  pfor_pkg::item_t item,
	output logic            pair_valid,
	input  wire             logic pair_stall,
	output pfor_pkg::pair_t pair
);

	logic          push;
	pfor_pkg::op_t push_op;
	logic          full;
	logic          pop;
	pfor_pkg::op_t head;
	logic          empty;

	pfor_front #(
		.BLOCK_LEN (BLOCK_LEN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.push       (push),
		.push_op    (push_op),
		.full       (full)
	);

	pfor_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (full),
		.pop     (pop),
		.head    (head),
		.empty   (empty)
	);

	pfor_back #(
		.BLOCK_LEN (BLOCK_LEN)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.empty      (empty),
		.pop        (pop),
		.pair_valid (pair_valid),
		.pair_stall (pair_stall),
		.pair       (pair)
	);

endmodule

`default_nettype wire

### src/pfor_front.sv
`default_nettype none

module pfor_front #(
	parameter int BLOCK_LEN = 128
) (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic item_valid,
	output logic               item_stall,
	input  pfor_pkg::item_t    item,
	output logic               push,
	output pfor_pkg::op_t      push_op,
	input  wire                logic full
);

	localparam int IW = $clog2(BLOCK_LEN);
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_LOAD  = 2'd1;
	localparam logic [1:0] PH_PATCH = 2'd2;

	logic [1:0]  phase_q;
	logic [IW-1:0] load_cnt_q;
	logic [2:0]  exc_left_q;
	logic [4:0]  width_q;
	logic        mode_q;
	logic [31:0] base_q;

	logic        accept;
	logic        load_last;
	logic        pos_ok;
	logic [31:0] patch_bits;

	// stall only on a full queue; out-of-order beats are taken and dropped
	assign item_stall = full;
	assign accept     = item_valid && !full;
	assign load_last  = load_cnt_q == IW'(BLOCK_LEN - 1);
	assign pos_ok     = 9'(item.exception_position) < 9'(BLOCK_LEN);
	// shift the exception byte above the packed width, drop what passes bit 31
	assign patch_bits = 32'(40'(item.exception_bits) << width_q);

	// classify the beat into a back-end operation
	always_comb begin
		push         = 1'b0;
		push_op      = '0;
		push_op.mode = mode_q;
		push_op.base = base_q;
		if (accept) begin
			unique case (item.command)
				pfor_pkg::CMD_START: begin
					if (phase_q == PH_IDLE && item.value_width == 5'd0) begin
						push         = 1'b1;
						push_op.op   = pfor_pkg::OP_FILL;
						push_op.data = item.value;
						push_op.emit = item.exception_count == 3'd0;
						push_op.mode = item.prefix_mode;
						push_op.base = item.base;
					end
				end
				pfor_pkg::CMD_LOW: begin
					if (phase_q == PH_LOAD) begin
						push         = 1'b1;
						push_op.op   = pfor_pkg::OP_WRITE;
						push_op.addr = pfor_pkg::ADDR_W'(load_cnt_q);
						push_op.data = item.value;
						push_op.emit = load_last && exc_left_q == 3'd0;
					end
				end
				pfor_pkg::CMD_EXC: begin
					if (phase_q == PH_PATCH) begin
						push_op.emit = exc_left_q == 3'd1;
						push_op.addr = pfor_pkg::ADDR_W'(item.exception_position);
						push_op.data = patch_bits;
						if (pos_ok) begin
							push       = 1'b1;
							push_op.op = pfor_pkg::OP_PATCH;
						end else if (exc_left_q == 3'd1) begin
							push       = 1'b1;
							push_op.op = pfor_pkg::OP_NONE;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// advance the block phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			load_cnt_q <= '0;
			exc_left_q <= '0;
			width_q    <= '0;
			mode_q     <= 1'b0;
			base_q     <= '0;
		end else if (accept) begin
			unique case (item.command)
				pfor_pkg::CMD_START: begin
					if (phase_q == PH_IDLE) begin
						mode_q     <= item.prefix_mode;
						width_q    <= item.value_width;
						exc_left_q <= item.exception_count;
						base_q     <= item.base;
						load_cnt_q <= '0;
						if (item.value_width != 5'd0) begin
							phase_q <= PH_LOAD;
						end else if (item.exception_count != 3'd0) begin
							phase_q <= PH_PATCH;
						end
					end
				end
				pfor_pkg::CMD_LOW: begin
					if (phase_q == PH_LOAD) begin
						load_cnt_q <= load_cnt_q + 1'b1;
						if (load_last) begin
							phase_q <= (exc_left_q == 3'd0) ? PH_IDLE : PH_PATCH;
						end
					end
				end
				pfor_pkg::CMD_EXC: begin
					if (phase_q == PH_PATCH) begin
						exc_left_q <= exc_left_q - 1'b1;
						if (exc_left_q == 3'd1) begin
							phase_q <= PH_IDLE;
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

### src/pfor_queue.sv
`default_nettype none

module pfor_queue (
	input  wire            logic clk,
	input  wire            logic arst_n,
	input  wire            logic push,
	input  pfor_pkg::op_t  push_op,
	output logic           full,
	input  wire            logic pop,
	output pfor_pkg::op_t  head,
	output logic           empty
);

	localparam int PW = $clog2(pfor_pkg::QUEUE_DEPTH);

	pfor_pkg::op_t entry_q [pfor_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   cnt_q;

	assign full  = cnt_q == (PW + 1)'(pfor_pkg::QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = entry_q[rd_ptr_q];

	// store the pushed operation
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

### src/pfor_back.sv
`default_nettype none

module pfor_back #(
	parameter int BLOCK_LEN = 128
) (
	input  wire             logic clk,
	input  wire             logic arst_n,
	input  pfor_pkg::op_t   head,
	input  wire             logic empty,
	output logic            pop,
	output logic            pair_valid,
	input  wire             logic pair_stall,
	output pfor_pkg::pair_t pair
);

	localparam int PAIRS = (BLOCK_LEN + 1) / 2;
	localparam int RW = $clog2(PAIRS);
	localparam logic [RW-1:0] LAST_ROW = RW'(PAIRS - 1);
	localparam logic ODD_LEN = (BLOCK_LEN % 2) == 1;

	localparam logic [1:0] B_IDLE  = 2'd0;
	localparam logic [1:0] B_FILL  = 2'd1;
	localparam logic [1:0] B_PATCH = 2'd2;
	localparam logic [1:0] B_EMIT  = 2'd3;

	// entry 2r lives in the even bank, entry 2r+1 in the odd bank, row r
	logic [31:0] even_mem [PAIRS];
	logic [31:0] odd_mem  [PAIRS];

	logic [1:0]    state_q;
	logic [RW-1:0] row_q;
	logic [31:0]   data_q;
	logic          bank_q;
	logic          emit_q;
	logic          mode_q;
	logic [31:0]   base_q;
	logic [31:0]   run_q;

	logic [31:0]   rd_even_s1;
	logic [31:0]   rd_odd_s1;
	logic          valid_s1;
	logic [RW-1:0] row_s1;
	logic          last_s1;
	logic          first_s1;
	logic          mode_s1;
	logic [31:0]   base_s1;

	logic          valid_s2;
	logic [31:0]   even_s2;
	logic [31:0]   odd_s2;
	logic [31:0]   sum_s2;
	logic [RW-1:0] row_s2;
	logic          last_s2;
	logic          first_s2;
	logic          mode_s2;
	logic [31:0]   base_s2;

	logic            pair_valid_q;
	pfor_pkg::pair_t pair_q;

	logic          adv;
	logic          issue;
	logic          patch_rd;
	logic          rd_en;
	logic [RW-1:0] rd_row;
	logic [RW-1:0] head_row;
	logic          head_bank;
	logic          we_even;
	logic          we_odd;
	logic [RW-1:0] wr_row;
	logic [31:0]   wr_data;
	logic [31:0]   odd_pick;
	logic [31:0]   run_base;

	assign head_row  = head.addr[RW:1];
	assign head_bank = head.addr[0];

	// whole emit pipeline moves when the output register can take a beat
	assign adv      = !pair_valid_q || !pair_stall;
	assign issue    = state_q == B_EMIT && adv;
	// a patch read waits until stage 1 holds no emitted row
	assign patch_rd = state_q == B_IDLE && !empty && head.op == pfor_pkg::OP_PATCH && !valid_s1;
	assign pop      = state_q == B_IDLE && !empty &&
		(head.op != pfor_pkg::OP_PATCH || !valid_s1);
	assign rd_en    = issue || patch_rd;
	assign rd_row   = (state_q == B_EMIT) ? row_q : head_row;

	// select the store write
	always_comb begin
		we_even = 1'b0;
		we_odd  = 1'b0;
		wr_row  = row_q;
		wr_data = data_q;
		unique case (state_q)
			B_IDLE: begin
				if (pop && head.op == pfor_pkg::OP_WRITE) begin
					we_even = !head_bank;
					we_odd  = head_bank;
					wr_row  = head_row;
					wr_data = head.data;
				end
			end
			B_FILL: begin
				we_even = 1'b1;
				we_odd  = 1'b1;
			end
			B_PATCH: begin
				we_even = !bank_q;
				we_odd  = bank_q;
				wr_data = data_q | (bank_q ? rd_odd_s1 : rd_even_s1);
			end
			default: ;
		endcase
	end

	// store banks with registered reads
	always_ff @(posedge clk) begin
		if (we_even) begin
			even_mem[wr_row] <= wr_data;
		end
		if (rd_en) begin
			rd_even_s1 <= even_mem[rd_row];
		end
	end

	always_ff @(posedge clk) begin
		if (we_odd) begin
			odd_mem[wr_row] <= wr_data;
		end
		if (rd_en) begin
			rd_odd_s1 <= odd_mem[rd_row];
		end
	end

	// sequence operations: fill sweep, patch write-back, pair drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			row_q   <= '0;
			emit_q  <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						emit_q <= head.emit;
						row_q  <= '0;
						unique case (head.op)
							pfor_pkg::OP_FILL: state_q <= B_FILL;
							pfor_pkg::OP_PATCH: begin
								state_q <= B_PATCH;
								row_q   <= head_row;
							end
							default: state_q <= head.emit ? B_EMIT : B_IDLE;
						endcase
					end
				end
				B_FILL: begin
					row_q <= row_q + 1'b1;
					if (row_q == LAST_ROW) begin
						row_q   <= '0;
						state_q <= emit_q ? B_EMIT : B_IDLE;
					end
				end
				B_PATCH: begin
					row_q   <= '0;
					state_q <= emit_q ? B_EMIT : B_IDLE;
				end
				B_EMIT: begin
					if (adv) begin
						row_q <= row_q + 1'b1;
						if (row_q == LAST_ROW) begin
							row_q   <= '0;
							state_q <= B_IDLE;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// hold the popped operation's payload
	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= head.data;
			bank_q <= head_bank;
			mode_q <= head.mode;
			base_q <= head.base;
		end
	end

	// stage valids and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			pair_valid_q <= 1'b0;
			run_q        <= '0;
		end else if (adv) begin
			valid_s1     <= issue;
			valid_s2     <= valid_s1;
			pair_valid_q <= valid_s2;
			if (valid_s2) begin
				run_q <= run_base + sum_s2;
			end
		end
	end

	// stage 1: tag the row being read
	always_ff @(posedge clk) begin
		if (issue) begin
			row_s1   <= row_q;
			last_s1  <= row_q == LAST_ROW;
			first_s1 <= row_q == '0;
			mode_s1  <= mode_q;
			base_s1  <= base_q;
		end
	end

	// odd block: the final pair has no odd entry
	assign odd_pick = (ODD_LEN && last_s1) ? 32'd0 : rd_odd_s1;

	// stage 2: form the pair sum
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			even_s2  <= rd_even_s1;
			odd_s2   <= odd_pick;
			sum_s2   <= rd_even_s1 + odd_pick;
			row_s2   <= row_s1;
			last_s2  <= last_s1;
			first_s2 <= first_s1;
			mode_s2  <= mode_s1;
			base_s2  <= base_s1;
		end
	end

	assign run_base = first_s2 ? base_s2 : run_q;

	// output register: plain entries or running sums; a missing odd entry stays zero
	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			pair_q.first_value  <= mode_s2 ? run_base + even_s2 : even_s2;
			pair_q.second_value <= (mode_s2 && !(ODD_LEN && last_s2)) ?
				run_base + sum_s2 : odd_s2;
			pair_q.pair_index   <= 6'(row_s2);
			pair_q.last         <= last_s2;
		end
	end

	assign pair_valid = pair_valid_q;
	assign pair       = pair_q;

endmodule

`default_nettype wire

### src/pfor_checker.sv
`default_nettype none

`include "pfor_exception_patch_prefix_sum_core_macros.svh"

module pfor_checker #(
	parameter int BLOCK_LEN = 128
) (
	input wire             logic clk,
	input wire             logic arst_n,
	input wire             logic pair_valid,
	input wire             logic pair_stall,
	input pfor_pkg::pair_t pair
);

	localparam int PAIRS = (BLOCK_LEN + 1) / 2;
	localparam logic [5:0] LAST_INDEX = 6'((PAIRS - 1) % 64);

	logic pair_take;

	assign pair_take = pair_valid && !pair_stall;

	// a stalled pair beat stays put
	`PFOR_ASSERT_NEXT(a_pair_hold, pair_valid && pair_stall, pair_valid && $stable(pair), "pair beat changed under stall")

	// the closing pair sits at the block's final index
	`PFOR_ASSERT_NOW(a_last_index, pair_valid && pair.last, pair.pair_index == LAST_INDEX, "last pair at wrong index")

	// pairs of one block come out in index order
	`PFOR_ASSERT_NEXT(a_index_step, pair_take && !pair.last, !pair_valid || pair.pair_index == 6'($past(pair.pair_index) + 6'd1), "pair index skipped")

	// a new block starts at pair zero
	`PFOR_ASSERT_NEXT(a_block_restart, pair_take && pair.last, !pair_valid || pair.pair_index == 6'd0, "block did not restart at zero")

endmodule

bind pfor_exception_patch_prefix_sum_core pfor_checker #(
	.BLOCK_LEN (BLOCK_LEN)
) u_pfor_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.pair_valid (pair_valid),
	.pair_stall (pair_stall),
	.pair       (pair)
);

`default_nettype wire

### tb/sv/pfor_exception_patch_prefix_sum_core_tb.sv
`default_nettype none

module pfor_exception_patch_prefix_sum_core_tb;

	localparam int BLOCK_LEN = 128;
	localparam int PAIRS = (BLOCK_LEN + 1) / 2;
	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int REPORT_MAX = 10;

	// block phases of the predictor
	localparam logic [1:0] BLK_IDLE  = 2'd0;
	localparam logic [1:0] BLK_LOAD  = 2'd1;
	localparam logic [1:0] BLK_PATCH = 2'd2;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  item_valid = 1'b0;
	logic  item_stall;
	pfor_pkg::item_t item = '0;
	logic  pair_valid;
	logic  pair_stall = 1'b0;
	pfor_pkg::pair_t pair;

	pfor_exception_patch_prefix_sum_core #(
		.BLOCK_LEN(BLOCK_LEN)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.pair_valid(pair_valid),
		.pair_stall(pair_stall),
		.pair      (pair)
	);

	// decoder state as seen from the input side
	logic [31:0] entries [BLOCK_LEN];
	int          loaded;
	logic [2:0]  patches_left;
	logic [1:0]  blk_state;
	logic [4:0]  shift_w;
	logic [31:0] sum_base;
	logic        sum_mode;

	pfor_pkg::item_t pending_items[$];
	pfor_pkg::pair_t expected_pairs[$];
	pfor_pkg::pair_t want_pair;

	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	bit hold_req = 1'b0;
	bit hold_taken;
	int hold_cnt;
	int bad_pairs = 0;
	int block_items = 0;
	int cycle_cnt = 0;

	// drain the finished block as pairs, plain or as a running sum from base
	task automatic emit_pairs();
		logic [31:0] acc;
		logic [31:0] a;
		logic [31:0] b;
		pfor_pkg::pair_t p;
		acc = sum_base;
		for (int k = 0; k < PAIRS; k++) begin
			a = entries[2 * k];
			b = (2 * k + 1 < BLOCK_LEN) ? entries[2 * k + 1] : 32'd0;
			if (sum_mode) begin
				acc = acc + a;
				a = acc;
				if (2 * k + 1 < BLOCK_LEN) begin
					acc = acc + b;
					b = acc;
				end
			end
			p.first_value = a;
			p.second_value = b;
			p.pair_index = 6'(k);
			p.last = (k == PAIRS - 1);
			expected_pairs.push_back(p);
		end
		blk_state = BLK_IDLE;
	endtask

	task automatic finish_loading();
		if (patches_left == 3'd0)
			emit_pairs();
		else
			blk_state = BLK_PATCH;
	endtask

	// advance the decoder by one accepted beat
	task automatic decode_item(input pfor_pkg::item_t it);
		if (it.command == pfor_pkg::CMD_START && blk_state == BLK_IDLE) begin
			sum_mode = it.prefix_mode;
			shift_w = it.value_width;
			patches_left = it.exception_count;
			sum_base = it.base;
			if (shift_w == 5'd0) begin
				for (int i = 0; i < BLOCK_LEN; i++)
					entries[i] = it.value;
				loaded = BLOCK_LEN;
				finish_loading();
			end else begin
				loaded = 0;
				blk_state = BLK_LOAD;
			end
		end else if (it.command == pfor_pkg::CMD_LOW && blk_state == BLK_LOAD) begin
			if (loaded < BLOCK_LEN)
				entries[loaded] = it.value;
			loaded++;
			if (loaded >= BLOCK_LEN)
				finish_loading();
		end else if (it.command == pfor_pkg::CMD_EXC && blk_state == BLK_PATCH) begin
			if (int'(it.exception_position) < BLOCK_LEN)
				entries[it.exception_position] = entries[it.exception_position] |
					(32'(it.exception_bits) << shift_w);
			patches_left = patches_left - 3'd1;
			if (patches_left == 3'd0)
				emit_pairs();
		end
	endtask

	// beat with every field random
	function automatic pfor_pkg::item_t any_item(logic [1:0] cmd);
		pfor_pkg::item_t it;
		it.command = cmd;
		it.prefix_mode = 1'($urandom_range(1));
		it.value_width = 5'($urandom_range(31));
		it.exception_count = 3'($urandom_range(7));
		it.base = $urandom;
		it.value = $urandom;
		it.exception_position = 7'($urandom_range(127));
		it.exception_bits = 8'($urandom_range(255));
		return it;
	endfunction

	function automatic pfor_pkg::item_t start_item(logic mode, logic [4:0] width,
			logic [2:0] cnt, logic [31:0] base, logic [31:0] fill);
		pfor_pkg::item_t it;
		it = any_item(pfor_pkg::CMD_START);
		it.prefix_mode = mode;
		it.value_width = width;
		it.exception_count = cnt;
		it.base = base;
		it.value = fill;
		return it;
	endfunction

	function automatic pfor_pkg::item_t low_item(logic [31:0] v);
		pfor_pkg::item_t it;
		it = any_item(pfor_pkg::CMD_LOW);
		it.value = v;
		return it;
	endfunction

	function automatic pfor_pkg::item_t exc_item(logic [6:0] pos, logic [7:0] bits);
		pfor_pkg::item_t it;
		it = any_item(pfor_pkg::CMD_EXC);
		it.exception_position = pos;
		it.exception_bits = bits;
		return it;
	endfunction

	// any command but the one the sequence expects next
	function automatic pfor_pkg::item_t noise_item(logic [1:0] in_order);
		logic [1:0] cmd;
		do
			cmd = 2'($urandom_range(3));
		while (cmd == in_order);
		return any_item(cmd);
	endfunction

	function automatic logic [31:0] edge_word();
		case ($urandom_range(7))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_noise(input logic [1:0] in_order);
		if ($urandom_range(9) == 0)
			pending_items.push_back(noise_item(in_order));
	endtask

	task automatic push_counted(input pfor_pkg::item_t it);
		pending_items.push_back(it);
		block_items++;
	endtask

	// one block: start, low parts unless shared, exceptions; sometimes cut short
	task automatic queue_block(input logic [4:0] width);
		logic [2:0] cnt;
		int n_exc;
		cnt = 3'($urandom_range(7));
		push_noise(pfor_pkg::CMD_START);
		push_counted(start_item(1'($urandom_range(1)), width, cnt, edge_word(), edge_word()));
		if (width != 5'd0) begin
			for (int i = 0; i < BLOCK_LEN; i++) begin
				push_noise(pfor_pkg::CMD_LOW);
				push_counted(low_item($urandom));
			end
		end
		n_exc = ($urandom_range(11) == 0) ? $urandom_range(cnt) : int'(cnt);
		for (int i = 0; i < n_exc; i++) begin
			push_noise(pfor_pkg::CMD_EXC);
			push_counted(exc_item(7'($urandom_range(127)), 8'($urandom_range(255))));
		end
	endtask

	// complete a block left open so the next phase starts from idle
	task automatic close_block();
		if (blk_state == BLK_LOAD) begin
			for (int i = loaded; i < BLOCK_LEN; i++)
				pending_items.push_back(low_item($urandom));
		end
		if (blk_state != BLK_IDLE) begin
			for (int i = 0; i < int'(patches_left); i++)
				pending_items.push_back(exc_item(7'($urandom_range(127)),
					8'($urandom_range(255))));
		end
	endtask

	// hold until every queued beat went in and every pair came out
	task automatic wait_drain();
		while (pending_items.size() != 0 || item_valid || expected_pairs.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		forever #2 clk = ~clk;
	end

	// input driver: hold a stalled beat, otherwise offer the next one or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
		end else begin
			if (item_valid && !item_stall)
				decode_item(item);
			if (!item_valid || !item_stall) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
					item_valid <= 1'b1;
					item <= pending_items.pop_front();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// output stall: one long hold-off on request, random stalls otherwise
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_stall <= 1'b0;
			hold_cnt <= 0;
			hold_taken <= 1'b0;
		end else if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_cnt <= HOLD_CYCLES;
			pair_stall <= 1'b1;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			pair_stall <= 1'b1;
		end else begin
			pair_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	// pair checker: compare each accepted beat with the oldest expected pair
	always @(posedge clk) begin
		if (arst_n && pair_valid && !pair_stall) begin
			if (expected_pairs.size() == 0) begin
				bad_pairs++;
				if (bad_pairs <= REPORT_MAX)
					$display("unexpected pair: first=%h second=%h idx=%0d last=%0b",
						pair.first_value, pair.second_value, pair.pair_index, pair.last);
			end else begin
				want_pair = expected_pairs.pop_front();
				if (pair.first_value !== want_pair.first_value ||
						pair.second_value !== want_pair.second_value ||
						pair.pair_index !== want_pair.pair_index ||
						pair.last !== want_pair.last) begin
					bad_pairs++;
					if (bad_pairs <= REPORT_MAX)
						$display("pair mismatch: exp %h %h %0d %0b, got %h %h %0d %0b",
							want_pair.first_value, want_pair.second_value,
							want_pair.pair_index, want_pair.last,
							pair.first_value, pair.second_value,
							pair.pair_index, pair.last);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		blk_state = BLK_IDLE;
		loaded = 0;
		patches_left = 3'd0;
		shift_w = 5'd0;
		sum_base = 32'd0;
		sum_mode = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// sender idles rarely, receiver often
		snd_idle_pct = 24;
		rcv_idle_pct = 81;

		// stray beats while idle
		pending_items.push_back(low_item(32'hFFFF_FFFF));
		pending_items.push_back(exc_item(7'd127, 8'hFF));
		pending_items.push_back(any_item(CMD_NONE));
		// shared value, no exceptions, plain and wrapping sum
		pending_items.push_back(start_item(1'b0, 5'd0, 3'd0, 32'd0, 32'd0));
		pending_items.push_back(start_item(1'b1, 5'd0, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		// all seven exceptions, first and last entries, with stray beats mixed in
		pending_items.push_back(start_item(1'b1, 5'd0, 3'd7, 32'd0, 32'd1));
		pending_items.push_back(exc_item(7'd0, 8'hFF));
		pending_items.push_back(any_item(pfor_pkg::CMD_START));
		pending_items.push_back(exc_item(7'd127, 8'hFF));
		pending_items.push_back(low_item($urandom));
		pending_items.push_back(exc_item(7'd0, 8'h00));
		pending_items.push_back(exc_item(7'd64, 8'h01));
		pending_items.push_back(any_item(CMD_NONE));
		pending_items.push_back(exc_item(7'd127, 8'h80));
		pending_items.push_back(exc_item(7'd1, 8'h7F));
		pending_items.push_back(exc_item(7'd126, 8'hAA));
		pending_items.push_back(start_item(1'b0, 5'd0, 3'd1, 32'h1234_5678, 32'h8000_0000));
		pending_items.push_back(exc_item(7'd63, 8'h55));

		block_items = 0;
		while (block_items < 45)
			queue_block(5'd0);
		wait_drain();
		close_block();
		wait_drain();

		// sender idles often, receiver rarely; one block of unpacked low parts
		snd_idle_pct = 81;
		rcv_idle_pct = 24;
		queue_block(($urandom_range(1) == 0) ? 5'd31 : 5'($urandom_range(1, 30)));
		wait_drain();
		close_block();
		wait_drain();

		// no idling, one long output hold-off so the input backs up
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		hold_req = 1'b1;
		block_items = 0;
		while (block_items < 45)
			queue_block(5'd0);
		wait_drain();

		repeat (40) @(negedge clk);
		if (bad_pairs == 0 && expected_pairs.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
+incdir+src
src/pfor_pkg.sv
src/pfor_front.sv
src/pfor_queue.sv
src/pfor_back.sv
src/pfor_exception_patch_prefix_sum_core.sv
src/pfor_checker.sv
tb/sv/pfor_exception_patch_prefix_sum_core_tb.sv
